// File: design/sph_boundary_collision_response_macros.svh
// Assertion macros for the boundary collision response block
`ifndef SPH_BOUNDARY_COLLISION_RESPONSE_MACROS_SVH
`define SPH_BOUNDARY_COLLISION_RESPONSE_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define SBCR_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sbcr assertion failed");

// Antecedent implies consequent in the same cycle
`define SBCR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbcr assertion failed");

`endif

// File: design/sbcr_pkg.sv
// Types, stage map and step functions for the boundary collision response pipeline
package sbcr_pkg;

    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 32;

    localparam int S_IN    = 0;
    localparam int S_K     = 1;
    localparam int S_SH    = 2;
    localparam int S_SQ    = 3;
    localparam int S_SUM   = 4;
    localparam int S_SQRT1 = 5;
    localparam int S_D1SET = S_SQRT1 + SQ_STEPS;
    localparam int S_DIV1  = S_D1SET + 1;
    localparam int S_N     = S_DIV1 + DV_STEPS;
    localparam int S_DOT   = S_N + 1;
    localparam int S_VN    = S_DOT + 1;
    localparam int S_NVN   = S_VN + 1;
    localparam int S_VT    = S_NVN + 1;
    localparam int S_VSQ   = S_VT + 1;
    localparam int S_VSUM  = S_VSQ + 1;
    localparam int S_SQRT2 = S_VSUM + 1;
    localparam int S_STOP  = S_SQRT2 + SQ_STEPS;
    localparam int S_DIV2  = S_STOP + 1;
    localparam int S_U     = S_DIV2 + DV_STEPS;
    localparam int S_UFL   = S_U + 1;
    localparam int S_RES   = S_UFL + 1;
    localparam int NSTG    = S_RES + 1;

    localparam logic [16:0] FRIC_ONE = 17'h10000;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } root_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] q;
    } quot_t;

    typedef struct packed {
        logic [31:0]       idx;
        logic [2:0][31:0]  npos;
        logic [2:0][31:0]  nvel;
        logic [2:0][31:0]  vel;
        logic [2:0][31:0]  pen;
        logic [2:0][31:0]  p;
        logic [2:0][31:0]  n;
        logic [16:0]       fric;
        logic              fz;
        logic              nz;
        logic              stop;
        logic [31:0]       mag;
        logic [4:0]        shamt;
        logic [2:0][63:0]  sq;
        root_t             root;
        logic [32:0]       dvs;
        logic [2:0]        neg;
        quot_t [2:0]       dv;
        logic [2:0][71:0]  prod;
        logic [35:0]       vn;
        logic [53:0]       nv;
        logic [37:0]       fl;
        logic [2:0][33:0]  vt;
        logic [2:0][32:0]  u;
    } pipe_t;

    // One step of the bitwise integer square root
    function automatic root_t sqrt_step(input root_t s, input logic [63:0] b);
        root_t       o;
        logic [63:0] t;
        o = s;
        t = s.r + b;
        if (s.x >= t)
        begin
            o.x = s.x - t;
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // One restoring division step, quotient bits enter MSB first
    function automatic quot_t div_step(input quot_t d, input logic [63:0] dsh);
        quot_t o;
        o = d;
        if (d.rem >= dsh)
        begin
            o.rem = d.rem - dsh;
            o.q   = {d.q[30:0], 1'b1};
        end
        else
        begin
            o.q = {d.q[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// File: design/sbcr_if.sv
// Channel interfaces: particle input, result output, friction configuration
interface sbcr_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [31:0]                   particle_index;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] vel_x;
    logic signed [COORD_WIDTH-1:0] vel_y;
    logic signed [COORD_WIDTH-1:0] vel_z;
    logic signed [COORD_WIDTH-1:0] pen_x;
    logic signed [COORD_WIDTH-1:0] pen_y;
    logic signed [COORD_WIDTH-1:0] pen_z;

    modport source (output valid, particle_index, pos_x, pos_y, pos_z,
                    vel_x, vel_y, vel_z, pen_x, pen_y, pen_z, input ready);
    modport sink   (input valid, particle_index, pos_x, pos_y, pos_z,
                    vel_x, vel_y, vel_z, pen_x, pen_y, pen_z, output ready);
endinterface

interface sbcr_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [31:0]                   out_index;
    logic signed [COORD_WIDTH-1:0] new_pos_x;
    logic signed [COORD_WIDTH-1:0] new_pos_y;
    logic signed [COORD_WIDTH-1:0] new_pos_z;
    logic signed [COORD_WIDTH-1:0] new_vel_x;
    logic signed [COORD_WIDTH-1:0] new_vel_y;
    logic signed [COORD_WIDTH-1:0] new_vel_z;

    modport source (output valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                    new_vel_x, new_vel_y, new_vel_z, input ready);
    modport sink   (input valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                    new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

interface sbcr_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: design/sph_boundary_collision_response.sv
// Boundary collision response: slip boundary with friction, Q16.16, fully pipelined
// One particle transaction is taken every cycle unless the result side stalls. Most of the
// pipeline is taken by two 32-step square roots (normal length and tangential speed) and
// two 32-step restoring dividers (normal and tangent direction), each one step per stage.
// A stall on the result side freezes the whole pipeline; input ready is low only while
// the last stage holds a result not yet taken. COORD_WIDTH covers 16..32. Friction
// writes are accepted every cycle and clamp to 1.0.
`include "sph_boundary_collision_response_macros.svh"

module sph_boundary_collision_response #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sbcr_in_if.sink                     particle,
    sbcr_out_if.source                  result,
    sbcr_cfg_if.sink                    cfg
);

    localparam int CW   = COORD_WIDTH;
    localparam int LAST = sbcr_pkg::NSTG - 1;
    localparam logic signed [71:0] SAT_HI = (72'sd1 <<< (CW - 1)) - 72'sd1;
    localparam logic signed [71:0] SAT_LO = -SAT_HI - 72'sd1;
    localparam logic signed [39:0] VT_LIM = 40'sd1 <<< 32;

    sbcr_pkg::pipe_t st_reg  [sbcr_pkg::NSTG];
    sbcr_pkg::pipe_t st_next [sbcr_pkg::NSTG];
    logic [sbcr_pkg::NSTG-1:0] vld_reg;
    logic [sbcr_pkg::NSTG-1:0] vld_next;
    logic [16:0]               fric_reg;
    logic [16:0]               fric_next;
    logic                      en;

    function automatic logic [31:0] sat(input logic signed [71:0] x);
        logic signed [71:0] y;
        y = x;
        if (x > SAT_HI)
        begin
            y = SAT_HI;
        end
        else if (x < SAT_LO)
        begin
            y = SAT_LO;
        end
        return y[31:0];
    endfunction

    // ---------------- handshake ----------------
    assign en             = !vld_reg[LAST] || result.ready;
    assign particle.ready = en;
    assign cfg.ready      = 1'b1;

    always_comb
    begin
        vld_next    = {vld_reg[sbcr_pkg::NSTG-2:0], particle.valid};
        fric_next   = fric_reg;
        if (cfg.valid)
        begin
            fric_next = (cfg.data > sbcr_pkg::FRIC_ONE) ? sbcr_pkg::FRIC_ONE : cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            fric_reg <= '0;
        end
        else
        begin
            fric_reg <= fric_next;
            if (en)
            begin
                vld_reg <= vld_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < sbcr_pkg::NSTG; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // ---------------- input capture, position, max |pen| ----------------
    always_comb
    begin
        logic signed [31:0] po [3];
        logic signed [31:0] pe [3];
        logic signed [31:0] ve [3];
        logic [31:0]        ab [3];
        po[0] = 32'(particle.pos_x);
        po[1] = 32'(particle.pos_y);
        po[2] = 32'(particle.pos_z);
        ve[0] = 32'(particle.vel_x);
        ve[1] = 32'(particle.vel_y);
        ve[2] = 32'(particle.vel_z);
        pe[0] = 32'(particle.pen_x);
        pe[1] = 32'(particle.pen_y);
        pe[2] = 32'(particle.pen_z);
        st_next[sbcr_pkg::S_IN]      = '0;
        st_next[sbcr_pkg::S_IN].idx  = particle.particle_index;
        st_next[sbcr_pkg::S_IN].fric = fric_reg;
        st_next[sbcr_pkg::S_IN].fz   = (fric_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            st_next[sbcr_pkg::S_IN].npos[i] = sat(72'(po[i]) - 72'(pe[i]));
            st_next[sbcr_pkg::S_IN].vel[i]  = ve[i];
            st_next[sbcr_pkg::S_IN].pen[i]  = pe[i];
            ab[i] = pe[i][31] ? (~pe[i] + 32'd1) : pe[i];
        end
        st_next[sbcr_pkg::S_IN].nz  = (pe[0] != '0) || (pe[1] != '0) || (pe[2] != '0);
        st_next[sbcr_pkg::S_IN].mag = ab[0];
        if (ab[1] > st_next[sbcr_pkg::S_IN].mag)
        begin
            st_next[sbcr_pkg::S_IN].mag = ab[1];
        end
        if (ab[2] > st_next[sbcr_pkg::S_IN].mag)
        begin
            st_next[sbcr_pkg::S_IN].mag = ab[2];
        end
    end

    // shift that brings the largest component to at least 2^30
    always_comb
    begin
        st_next[sbcr_pkg::S_K]       = st_reg[sbcr_pkg::S_K-1];
        st_next[sbcr_pkg::S_K].shamt = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (st_reg[sbcr_pkg::S_K-1].mag[b])
            begin
                st_next[sbcr_pkg::S_K].shamt = (b >= 30) ? 5'd0 : 5'(30 - b);
            end
        end
    end

    always_comb
    begin
        st_next[sbcr_pkg::S_SH] = st_reg[sbcr_pkg::S_SH-1];
        for (int i = 0; i < 3; i++)
        begin
            st_next[sbcr_pkg::S_SH].p[i] =
                st_reg[sbcr_pkg::S_SH-1].pen[i] << st_reg[sbcr_pkg::S_SH-1].shamt;
        end
    end

    always_comb
    begin
        logic signed [63:0] m [3];
        st_next[sbcr_pkg::S_SQ] = st_reg[sbcr_pkg::S_SQ-1];
        for (int i = 0; i < 3; i++)
        begin
            m[i] = $signed(st_reg[sbcr_pkg::S_SQ-1].p[i]) *
                   $signed(st_reg[sbcr_pkg::S_SQ-1].p[i]);
            st_next[sbcr_pkg::S_SQ].sq[i] = m[i];
        end
    end

    always_comb
    begin
        st_next[sbcr_pkg::S_SUM]        = st_reg[sbcr_pkg::S_SUM-1];
        st_next[sbcr_pkg::S_SUM].root.x = st_reg[sbcr_pkg::S_SUM-1].sq[0] +
                                          st_reg[sbcr_pkg::S_SUM-1].sq[1] +
                                          st_reg[sbcr_pkg::S_SUM-1].sq[2];
        st_next[sbcr_pkg::S_SUM].root.r = '0;
    end

    // ---------------- square root and divider chains ----------------
    for (genvar j = 0; j < sbcr_pkg::SQ_STEPS; j++)
    begin : g_sqrt
        localparam int SA = sbcr_pkg::S_SQRT1 + j;
        localparam int SB = sbcr_pkg::S_SQRT2 + j;
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        always_comb
        begin
            st_next[SA]      = st_reg[SA-1];
            st_next[SA].root = sbcr_pkg::sqrt_step(st_reg[SA-1].root, BIT);
            st_next[SB]      = st_reg[SB-1];
            st_next[SB].root = sbcr_pkg::sqrt_step(st_reg[SB-1].root, BIT);
        end
    end

    for (genvar j = 0; j < sbcr_pkg::DV_STEPS; j++)
    begin : g_div
        localparam int SA = sbcr_pkg::S_DIV1 + j;
        localparam int SB = sbcr_pkg::S_DIV2 + j;
        localparam int SH = sbcr_pkg::DV_STEPS - 1 - j;
        always_comb
        begin
            st_next[SA] = st_reg[SA-1];
            st_next[SB] = st_reg[SB-1];
            for (int i = 0; i < 3; i++)
            begin
                st_next[SA].dv[i] = sbcr_pkg::div_step(st_reg[SA-1].dv[i],
                                                        64'(st_reg[SA-1].dvs) << SH);
                st_next[SB].dv[i] = sbcr_pkg::div_step(st_reg[SB-1].dv[i],
                                                        64'(st_reg[SB-1].dvs) << SH);
            end
        end
    end

    // normal: |p| * 2^30 / L
    always_comb
    begin
        logic [31:0] ab;
        st_next[sbcr_pkg::S_D1SET]     = st_reg[sbcr_pkg::S_D1SET-1];
        st_next[sbcr_pkg::S_D1SET].dvs = st_reg[sbcr_pkg::S_D1SET-1].root.r[32:0];
        for (int i = 0; i < 3; i++)
        begin
            ab = st_reg[sbcr_pkg::S_D1SET-1].p[i][31] ?
                 (~st_reg[sbcr_pkg::S_D1SET-1].p[i] + 32'd1) :
                 st_reg[sbcr_pkg::S_D1SET-1].p[i];
            st_next[sbcr_pkg::S_D1SET].neg[i]    = st_reg[sbcr_pkg::S_D1SET-1].p[i][31];
            st_next[sbcr_pkg::S_D1SET].dv[i].rem = 64'(ab) << 30;
            st_next[sbcr_pkg::S_D1SET].dv[i].q   = '0;
        end
    end

    always_comb
    begin
        st_next[sbcr_pkg::S_N] = st_reg[sbcr_pkg::S_N-1];
        for (int i = 0; i < 3; i++)
        begin
            if (!st_reg[sbcr_pkg::S_N-1].nz)
            begin
                st_next[sbcr_pkg::S_N].n[i] = '0;
            end
            else if (st_reg[sbcr_pkg::S_N-1].neg[i])
            begin
                st_next[sbcr_pkg::S_N].n[i] = ~st_reg[sbcr_pkg::S_N-1].dv[i].q + 32'd1;
            end
            else
            begin
                st_next[sbcr_pkg::S_N].n[i] = st_reg[sbcr_pkg::S_N-1].dv[i].q;
            end
        end
    end

    // ---------------- normal speed and tangential velocity ----------------
    always_comb
    begin
        logic signed [63:0] m;
        st_next[sbcr_pkg::S_DOT] = st_reg[sbcr_pkg::S_DOT-1];
        for (int i = 0; i < 3; i++)
        begin
            m = $signed(st_reg[sbcr_pkg::S_DOT-1].vel[i]) *
                $signed(st_reg[sbcr_pkg::S_DOT-1].n[i]);
            st_next[sbcr_pkg::S_DOT].prod[i] = 72'(m);
        end
    end

    always_comb
    begin
        logic signed [65:0] acc;
        st_next[sbcr_pkg::S_VN] = st_reg[sbcr_pkg::S_VN-1];
        acc = $signed(st_reg[sbcr_pkg::S_VN-1].prod[0][65:0]) +
              $signed(st_reg[sbcr_pkg::S_VN-1].prod[1][65:0]) +
              $signed(st_reg[sbcr_pkg::S_VN-1].prod[2][65:0]);
        st_next[sbcr_pkg::S_VN].vn = 36'(acc >>> 30);
    end

    always_comb
    begin
        logic signed [67:0] m;
        logic signed [53:0] t;
        st_next[sbcr_pkg::S_NVN] = st_reg[sbcr_pkg::S_NVN-1];
        for (int i = 0; i < 3; i++)
        begin
            m = $signed(st_reg[sbcr_pkg::S_NVN-1].n[i]) *
                $signed(st_reg[sbcr_pkg::S_NVN-1].vn);
            st_next[sbcr_pkg::S_NVN].prod[i] = 72'(m);
        end
        t = (-$signed(st_reg[sbcr_pkg::S_NVN-1].vn)) *
            $signed({1'b0, st_reg[sbcr_pkg::S_NVN-1].fric});
        st_next[sbcr_pkg::S_NVN].nv = t;
    end

    always_comb
    begin
        logic signed [39:0] t;
        logic signed [37:0] f;
        st_next[sbcr_pkg::S_VT] = st_reg[sbcr_pkg::S_VT-1];
        for (int i = 0; i < 3; i++)
        begin
            t = 40'($signed(st_reg[sbcr_pkg::S_VT-1].vel[i]) -
                    ($signed(st_reg[sbcr_pkg::S_VT-1].prod[i]) >>> 30));
            if (t > VT_LIM)
            begin
                t = VT_LIM;
            end
            else if (t < -VT_LIM)
            begin
                t = -VT_LIM;
            end
            st_next[sbcr_pkg::S_VT].vt[i] = t[33:0];
        end
        f = 38'($signed(st_reg[sbcr_pkg::S_VT-1].nv) >>> 16);
        st_next[sbcr_pkg::S_VT].fl = f;
    end

    // ---------------- tangential speed ----------------
    always_comb
    begin
        logic [33:0] a;
        st_next[sbcr_pkg::S_VSQ] = st_reg[sbcr_pkg::S_VSQ-1];
        for (int i = 0; i < 3; i++)
        begin
            a = st_reg[sbcr_pkg::S_VSQ-1].vt[i][33] ?
                (~st_reg[sbcr_pkg::S_VSQ-1].vt[i] + 34'd1) :
                st_reg[sbcr_pkg::S_VSQ-1].vt[i];
            st_next[sbcr_pkg::S_VSQ].sq[i] = a[32] ? '1 : 64'(a[31:0]) * 64'(a[31:0]);
        end
    end

    always_comb
    begin
        logic [64:0] s1;
        logic [64:0] s2;
        logic [63:0] c1;
        st_next[sbcr_pkg::S_VSUM] = st_reg[sbcr_pkg::S_VSUM-1];
        s1 = 65'(st_reg[sbcr_pkg::S_VSUM-1].sq[0]) + 65'(st_reg[sbcr_pkg::S_VSUM-1].sq[1]);
        c1 = s1[64] ? '1 : s1[63:0];
        s2 = 65'(c1) + 65'(st_reg[sbcr_pkg::S_VSUM-1].sq[2]);
        st_next[sbcr_pkg::S_VSUM].root.x = s2[64] ? '1 : s2[63:0];
        st_next[sbcr_pkg::S_VSUM].root.r = '0;
    end

    // stop test and tangent direction setup
    always_comb
    begin
        logic [32:0] vlen;
        logic [33:0] a;
        st_next[sbcr_pkg::S_STOP] = st_reg[sbcr_pkg::S_STOP-1];
        vlen = st_reg[sbcr_pkg::S_STOP-1].root.r[32:0];
        st_next[sbcr_pkg::S_STOP].dvs  = vlen;
        st_next[sbcr_pkg::S_STOP].stop = !st_reg[sbcr_pkg::S_STOP-1].fz &&
            (($signed(st_reg[sbcr_pkg::S_STOP-1].fl) >= $signed({5'd0, vlen})) ||
             (vlen == '0));
        for (int i = 0; i < 3; i++)
        begin
            a = st_reg[sbcr_pkg::S_STOP-1].vt[i][33] ?
                (~st_reg[sbcr_pkg::S_STOP-1].vt[i] + 34'd1) :
                st_reg[sbcr_pkg::S_STOP-1].vt[i];
            st_next[sbcr_pkg::S_STOP].neg[i]    = st_reg[sbcr_pkg::S_STOP-1].vt[i][33];
            st_next[sbcr_pkg::S_STOP].dv[i].rem = 64'(a) << 30;
            st_next[sbcr_pkg::S_STOP].dv[i].q   = '0;
        end
    end

    always_comb
    begin
        st_next[sbcr_pkg::S_U] = st_reg[sbcr_pkg::S_U-1];
        for (int i = 0; i < 3; i++)
        begin
            st_next[sbcr_pkg::S_U].u[i] = st_reg[sbcr_pkg::S_U-1].neg[i] ?
                (~{1'b0, st_reg[sbcr_pkg::S_U-1].dv[i].q} + 33'd1) :
                {1'b0, st_reg[sbcr_pkg::S_U-1].dv[i].q};
        end
    end

    // fl < |vt| whenever this product is used, so 34 bits of fl suffice
    always_comb
    begin
        logic signed [66:0] m;
        st_next[sbcr_pkg::S_UFL] = st_reg[sbcr_pkg::S_UFL-1];
        for (int i = 0; i < 3; i++)
        begin
            m = $signed(st_reg[sbcr_pkg::S_UFL-1].u[i]) *
                $signed(st_reg[sbcr_pkg::S_UFL-1].fl[33:0]);
            st_next[sbcr_pkg::S_UFL].prod[i] = 72'(m);
        end
    end

    always_comb
    begin
        logic signed [71:0] t;
        logic signed [71:0] v;
        st_next[sbcr_pkg::S_RES] = st_reg[sbcr_pkg::S_RES-1];
        for (int i = 0; i < 3; i++)
        begin
            v = 72'($signed(st_reg[sbcr_pkg::S_RES-1].vt[i]));
            t = v - ($signed(st_reg[sbcr_pkg::S_RES-1].prod[i]) >>> 30);
            if (st_reg[sbcr_pkg::S_RES-1].fz)
            begin
                st_next[sbcr_pkg::S_RES].nvel[i] = sat(v);
            end
            else if (st_reg[sbcr_pkg::S_RES-1].stop)
            begin
                st_next[sbcr_pkg::S_RES].nvel[i] = '0;
            end
            else
            begin
                st_next[sbcr_pkg::S_RES].nvel[i] = sat(t);
            end
        end
    end

    // ---------------- result ----------------
    assign result.valid     = vld_reg[LAST];
    assign result.out_index = st_reg[LAST].idx;
    assign result.new_pos_x = st_reg[LAST].npos[0][CW-1:0];
    assign result.new_pos_y = st_reg[LAST].npos[1][CW-1:0];
    assign result.new_pos_z = st_reg[LAST].npos[2][CW-1:0];
    assign result.new_vel_x = st_reg[LAST].nvel[0][CW-1:0];
    assign result.new_vel_y = st_reg[LAST].nvel[1][CW-1:0];
    assign result.new_vel_z = st_reg[LAST].nvel[2][CW-1:0];

    // ---------------- assertions ----------------
    `SBCR_ASSERT_ALWAYS(a_fric_clamped, clk, rst_n, fric_reg <= sbcr_pkg::FRIC_ONE)
    `SBCR_ASSERT_IMPLIES(a_norm_len, clk, rst_n,
        vld_reg[sbcr_pkg::S_D1SET] && st_reg[sbcr_pkg::S_D1SET].nz,
        st_reg[sbcr_pkg::S_D1SET].dvs[32:30] != 3'd0)
    `SBCR_ASSERT_IMPLIES(a_no_stop_wo_fric, clk, rst_n,
        vld_reg[sbcr_pkg::S_STOP] && st_reg[sbcr_pkg::S_STOP].fz,
        !st_reg[sbcr_pkg::S_STOP].stop)
    `SBCR_ASSERT_IMPLIES(a_stop_zero_vel, clk, rst_n,
        vld_reg[LAST] && st_reg[LAST].stop,
        st_reg[LAST].nvel == '0)

endmodule
